FILE: src/hcg_pkg.sv
package hcg_pkg;

	// fixed field widths
	localparam int DUR_BITS       = 18;
	localparam int MV_BITS        = 3;
	localparam int FS_BITS        = 12;
	localparam int VOLT_BITS      = 16;
	localparam int PPM_BITS       = 16;
	localparam int CFG_DATA_BITS  = 18;
	localparam int CFG_INDEX_BITS = 2;

	// register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DRIVE_ON   = 2'd0,
		REG_DRIVE_OFF  = 2'd1,
		REG_MAX_VOLT   = 2'd2,
		REG_FULL_SCALE = 2'd3
	} cfg_reg_t;

	// register reset values
	localparam logic [DUR_BITS-1:0] DRIVE_ON_RST  = 18'd90000;
	localparam logic [DUR_BITS-1:0] DRIVE_OFF_RST = 18'd60000;
	localparam logic [MV_BITS-1:0]  MAX_VOLT_RST  = 3'd5;
	localparam logic [FS_BITS-1:0]  FULL_SCALE_RST = 12'd1023;

	// fixed point constants
	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [28:0] K_Q28   = 29'd414301982;  // 1.0698/ln2 in q.28
	localparam logic [28:0] C_Q28   = 29'd428929975;  // log2(3.027) in q.28
	localparam logic [30:0] RCP6    = 31'd1431655765; // floor(2^33/6)
	localparam logic [30:0] SIX     = 31'd6;
	localparam logic [VOLT_BITS-1:0] VOLT_MAX = 16'hFFFF;
	localparam logic [PPM_BITS-1:0]  PPM_MAX  = 16'hFFFF;

	// what the front tells the back about one tick
	typedef struct packed {
		logic heater_on;
		logic reading;
	} tick_flags_t;

endpackage

FILE: src/hcg_front.sv
module hcg_front #(
	parameter int ELAPSED_BITS = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [hcg_pkg::DUR_BITS-1:0]  drive_on_ms,
	input  logic [hcg_pkg::DUR_BITS-1:0]  drive_off_ms,
	output hcg_pkg::tick_flags_t          flags
);
	import hcg_pkg::*;

	localparam int CMP_W = (ELAPSED_BITS > DUR_BITS) ? ELAPSED_BITS : DUR_BITS;

	logic                    phase_on_q;
	logic [ELAPSED_BITS-1:0] elapsed_q;
	logic [ELAPSED_BITS-1:0] elapsed_inc;
	logic [CMP_W-1:0]        limit;
	logic [CMP_W-1:0]        count_ext;
	logic                    expire;

	// saturating tick count, then compare against the current phase length
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
	assign limit       = CMP_W'(phase_on_q ? drive_on_ms : drive_off_ms);
	assign count_ext   = CMP_W'(elapsed_inc);
	assign expire      = count_ext >= limit;

	assign flags.heater_on = phase_on_q ^ expire;
	assign flags.reading   = expire & ~phase_on_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_on_q <= 1'b1;
			elapsed_q  <= '0;
		end else if (accept) begin
			phase_on_q <= flags.heater_on;
			elapsed_q  <= expire ? '0 : elapsed_inc;
		end
	end

endmodule

FILE: src/hcg_fifo.sv
module hcg_fifo #(
	parameter int WIDTH = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic             nonempty,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign full     = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign dout     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: src/hcg_div.sv
module hcg_div #(
	parameter int DW = 30,
	parameter int VW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CNT_W = $clog2(DW);

	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [VW:0]      trial;
	logic [VW:0]      diff;
	logic             ge;
	logic             last;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};
	assign last  = cnt_q == CNT_W'(DW - 1);

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: src/hcg_back.sv
module hcg_back #(
	parameter int ADC_BITS          = 12,
	parameter int EXP_TABLE_ENTRIES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  hcg_pkg::tick_flags_t          head_flags,
	input  logic [ADC_BITS-1:0]           head_sample,
	output logic                          head_pop,
	input  logic [hcg_pkg::MV_BITS-1:0]   max_voltage,
	input  logic [hcg_pkg::FS_BITS-1:0]   adc_full_scale,
	input  logic                          res_pop,
	output logic                          res_valid,
	output logic                          heater_on,
	output logic                          reading_valid,
	output logic [hcg_pkg::PPM_BITS-1:0]  ppm_value
);
	import hcg_pkg::*;

	localparam int IDX_W   = $clog2(EXP_TABLE_ENTRIES);
	localparam int N_W     = $clog2(EXP_TABLE_ENTRIES + 1);
	localparam int NUM_W   = ADC_BITS + MV_BITS + 12;
	localparam int DIV_W   = NUM_W;
	localparam int DIV_VW  = FS_BITS;
	localparam int FN_W    = 28 + N_W;
	// floor(x/N) for 30-bit x by a rounded-up reciprocal, exact over that range
	localparam int          ZSH   = 30 + IDX_W;
	localparam logic [31:0] RCP_N = 32'(((64'd1 << ZSH) + 64'(EXP_TABLE_ENTRIES) - 64'd1)
		/ 64'(EXP_TABLE_ENTRIES));

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_DIVV = 13'b0000000000010,
		ST_MULK = 13'b0000000000100,
		ST_EXP  = 13'b0000000001000,
		ST_FRAC = 13'b0000000010000,
		ST_MULR = 13'b0000000100000,
		ST_DIVZ = 13'b0000001000000,
		ST_SQ   = 13'b0000010000000,
		ST_CUBE = 13'b0000100000000,
		ST_RCP  = 13'b0001000000000,
		ST_POLY = 13'b0010000000000,
		ST_MANT = 13'b0100000000000,
		ST_FIN  = 13'b1000000000000
	} state_t;

	// 2^(i/N) in q.30, series evaluated at elaboration
	logic [31:0] pow2_tab [EXP_TABLE_ENTRIES];

	for (genvar gi = 0; gi < EXP_TABLE_ENTRIES; gi++) begin : g_tab
		localparam logic [63:0] W   = (64'(gi) * LN2_Q30) / EXP_TABLE_ENTRIES;
		localparam logic [63:0] T1  = ((Q30_ONE * W) >> 30) / 1;
		localparam logic [63:0] T2  = ((T1 * W) >> 30) / 2;
		localparam logic [63:0] T3  = ((T2 * W) >> 30) / 3;
		localparam logic [63:0] T4  = ((T3 * W) >> 30) / 4;
		localparam logic [63:0] T5  = ((T4 * W) >> 30) / 5;
		localparam logic [63:0] T6  = ((T5 * W) >> 30) / 6;
		localparam logic [63:0] T7  = ((T6 * W) >> 30) / 7;
		localparam logic [63:0] T8  = ((T7 * W) >> 30) / 8;
		localparam logic [63:0] T9  = ((T8 * W) >> 30) / 9;
		localparam logic [63:0] T10 = ((T9 * W) >> 30) / 10;
		localparam logic [63:0] T11 = ((T10 * W) >> 30) / 11;
		localparam logic [63:0] T12 = ((T11 * W) >> 30) / 12;
		localparam logic [63:0] T13 = ((T12 * W) >> 30) / 13;
		localparam logic [63:0] T14 = ((T13 * W) >> 30) / 14;
		localparam logic [63:0] T15 = ((T14 * W) >> 30) / 15;
		localparam logic [63:0] T16 = ((T15 * W) >> 30) / 16;
		localparam logic [63:0] S   = Q30_ONE + T1 + T2 + T3 + T4 + T5 + T6 + T7 + T8
			+ T9 + T10 + T11 + T12 + T13 + T14 + T15 + T16;
		assign pow2_tab[gi] = S[31:0];
	end

	state_t               state_q;
	logic                 heater_q;
	logic                 sat_q;
	logic [VOLT_BITS-1:0] v_q;
	logic [44:0]          prodk_q;
	logic [27:0]          efrac_q;
	logic [3:0]           n_q;
	logic [IDX_W-1:0]     idx_q;
	logic [27:0]          r_q;
	logic [29:0]          rlh_q;
	logic [29:0]          z_q;
	logic [29:0]          z2_q;
	logic [29:0]          z3_q;
	logic [27:0]          q6_q;
	logic [31:0]          sum_q;
	logic [31:0]          poly_q;
	logic [33:0]          mant_q;

	logic                 res_valid_q;
	logic                 res_heater_q;
	logic                 res_reading_q;
	logic [PPM_BITS-1:0]  res_ppm_q;

	logic [NUM_W-1:0]     num;
	logic [57:0]          rl;
	logic [61:0]          zp;
	logic [33:0]          e_sum;
	logic [FN_W-1:0]      fn;
	logic [59:0]          zz;
	logic [59:0]          zzz;
	logic [60:0]          rp;
	logic [30:0]          r6;
	logic [63:0]          mp;
	logic [4:0]           shamt;
	logic [33:0]          shifted;
	logic [PPM_BITS-1:0]  ppm_fin;

	logic                 div_start;
	logic [DIV_W-1:0]     div_dividend;
	logic [DIV_VW-1:0]    div_divisor;
	logic                 div_done;
	logic [DIV_W-1:0]     div_quo;
	logic                 take;

	assign take     = (state_q == ST_IDLE) && head_valid && !res_valid_q;
	assign head_pop = take;

	assign num   = (NUM_W'(head_sample) * NUM_W'(max_voltage)) << 12;
	assign rl    = 58'(r_q) * 58'(LN2_Q30);
	assign zp    = 62'(rlh_q) * 62'(RCP_N);
	assign e_sum = 34'(prodk_q[44:12]) + 34'(C_Q28);
	assign fn    = FN_W'(efrac_q) * FN_W'(EXP_TABLE_ENTRIES);
	assign zz    = 60'(z_q) * 60'(z_q);
	assign zzz   = 60'(z2_q) * 60'(z_q);
	assign rp    = 61'(z3_q) * 61'(RCP6);
	assign r6    = 31'(z3_q) - 31'(q6_q) * SIX;
	assign mp    = 64'(pow2_tab[idx_q]) * 64'(poly_q);
	assign shamt = 5'd30 - 5'(n_q);
	assign shifted = mant_q >> shamt;
	assign ppm_fin = (sat_q || (|shifted[33:16])) ? PPM_MAX : shifted[15:0];

	// bit-serial divider for the volts quotient
	assign div_start    = take && head_flags.reading && (adc_full_scale != '0);
	assign div_dividend = num;
	assign div_divisor  = adc_full_scale;

	hcg_div #(
		.DW (DIV_W),
		.VW (DIV_VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					heater_q <= head_flags.heater_on;
					sat_q    <= 1'b0;
					v_q      <= VOLT_MAX;
				end
			end
			ST_DIVV: begin
				if (div_done) begin
					v_q <= (|div_quo[DIV_W-1:VOLT_BITS]) ? VOLT_MAX : div_quo[VOLT_BITS-1:0];
				end
			end
			ST_MULK: prodk_q <= 45'(v_q) * 45'(K_Q28);
			ST_EXP: begin
				efrac_q <= e_sum[27:0];
				n_q     <= e_sum[31:28];
				sat_q   <= |e_sum[33:32];
			end
			ST_FRAC: begin
				idx_q <= fn[28 +: IDX_W];
				r_q   <= fn[27:0];
			end
			ST_MULR: rlh_q <= rl[57:28];
			ST_DIVZ: z_q <= 30'(zp >> ZSH);
			ST_SQ:   z2_q <= zz[59:30];
			ST_CUBE: z3_q <= zzz[59:30];
			ST_RCP: begin
				q6_q  <= rp[60:33];
				sum_q <= 32'(Q30_ONE) + 32'(z_q) + 32'(z2_q >> 1);
			end
			ST_POLY: poly_q <= sum_q + 32'(q6_q) + 32'(r6 >= SIX);
			ST_MANT: mant_q <= mp[63:30];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (res_pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (!head_flags.reading) begin
							res_valid_q <= 1'b1;
						end else if (adc_full_scale == '0) begin
							state_q <= ST_MULK;
						end else begin
							state_q <= ST_DIVV;
						end
					end
				end
				ST_DIVV: begin
					if (div_done) begin
						state_q <= ST_MULK;
					end
				end
				ST_MULK: state_q <= ST_EXP;
				ST_EXP:  state_q <= (|e_sum[33:32]) ? ST_FIN : ST_FRAC;
				ST_FRAC: state_q <= ST_MULR;
				ST_MULR: state_q <= ST_DIVZ;
				ST_DIVZ: state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_CUBE;
				ST_CUBE: state_q <= ST_RCP;
				ST_RCP:  state_q <= ST_POLY;
				ST_POLY: state_q <= ST_MANT;
				ST_MANT: state_q <= ST_FIN;
				ST_FIN: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take && !head_flags.reading) begin
			res_heater_q  <= head_flags.heater_on;
			res_reading_q <= 1'b0;
			res_ppm_q     <= '0;
		end else if (state_q == ST_FIN) begin
			res_heater_q  <= heater_q;
			res_reading_q <= 1'b1;
			res_ppm_q     <= ppm_fin;
		end
	end

	assign res_valid     = res_valid_q;
	assign heater_on     = res_heater_q;
	assign reading_valid = res_reading_q;
	assign ppm_value     = res_ppm_q;

`ifndef ASSERT_OFF
	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !res_valid_q)
		else $error("result word present while a conversion runs");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIVV))
		else $error("divider finished with no stage waiting for it");

	a_plain_tick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_reading_q) |-> (res_ppm_q == '0))
		else $error("ppm not zero on a word without a reading");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_pop) |=> (res_valid_q && $stable(res_ppm_q)))
		else $error("waiting result word changed before it was taken");
`endif

endmodule

FILE: src/heater_cycle_gas_ppm_core.sv
// a tick that starts no reading goes through the queue straight into the result word
// a tick that switches the drive on also waits on the bit-serial volts divider
//   and on the exponent and mantissa steps
// the back takes a new tick only when idle and once the last result word was popped
// reset: arst_n clears drive phase to on, tick count, queue and result word;
//   registers return to 90000, 60000, 5 and 1023
module heater_cycle_gas_ppm_core #(
	parameter int ELAPSED_BITS      = 18,
	parameter int ADC_BITS          = 12,
	parameter int EXP_TABLE_ENTRIES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// tick input side
	input  logic                                push,
	output logic                                full,
	input  logic [ADC_BITS-1:0]                 adc_sample,
	// result side
	output logic                                empty,
	input  logic                                pop,
	output logic                                heater_on,
	output logic                                reading_valid,
	output logic [hcg_pkg::PPM_BITS-1:0]        ppm_value,
	// register write port
	input  logic                                cfg_write,
	input  logic [hcg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [hcg_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import hcg_pkg::*;

	localparam int ENTRY_W = ADC_BITS + $bits(tick_flags_t);

	// configuration registers
	logic [DUR_BITS-1:0] drive_on_q;
	logic [DUR_BITS-1:0] drive_off_q;
	logic [MV_BITS-1:0]  max_volt_q;
	logic [FS_BITS-1:0]  full_scale_q;

	logic                accept;
	tick_flags_t         front_flags;
	tick_flags_t         head_flags;
	logic [ENTRY_W-1:0]  fifo_din;
	logic [ENTRY_W-1:0]  fifo_dout;
	logic                fifo_full;
	logic                fifo_nonempty;
	logic                head_pop;
	logic                res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_on_q   <= DRIVE_ON_RST;
			drive_off_q  <= DRIVE_OFF_RST;
			max_volt_q   <= MAX_VOLT_RST;
			full_scale_q <= FULL_SCALE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DRIVE_ON:   drive_on_q   <= cfg_data[DUR_BITS-1:0];
				REG_DRIVE_OFF:  drive_off_q  <= cfg_data[DUR_BITS-1:0];
				REG_MAX_VOLT:   max_volt_q   <= cfg_data[MV_BITS-1:0];
				REG_FULL_SCALE: full_scale_q <= cfg_data[FS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// a tick word is taken whenever the queue has room
	assign accept = push && !fifo_full;
	assign full   = fifo_full;

	// front: phase timer, decides per tick whether a reading is due
	hcg_front #(
		.ELAPSED_BITS (ELAPSED_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.drive_on_ms  (drive_on_q),
		.drive_off_ms (drive_off_q),
		.flags        (front_flags)
	);

	// short queue of classified ticks between front and back
	assign fifo_din = {front_flags, adc_sample};

	hcg_fifo #(
		.WIDTH (ENTRY_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.din      (fifo_din),
		.full     (fifo_full),
		.pop      (head_pop),
		.nonempty (fifo_nonempty),
		.dout     (fifo_dout)
	);

	assign head_flags = tick_flags_t'(fifo_dout[ADC_BITS +: $bits(tick_flags_t)]);

	// back: volts divide, exponent, mantissa and result register
	hcg_back #(
		.ADC_BITS          (ADC_BITS),
		.EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (fifo_nonempty),
		.head_flags     (head_flags),
		.head_sample    (fifo_dout[ADC_BITS-1:0]),
		.head_pop       (head_pop),
		.max_voltage    (max_volt_q),
		.adc_full_scale (full_scale_q),
		.res_pop        (pop),
		.res_valid      (res_valid),
		.heater_on      (heater_on),
		.reading_valid  (reading_valid),
		.ppm_value      (ppm_value)
	);

	assign empty = !res_valid;

endmodule
